// ----- rtl/vrp_pkg.sv -----
package vrp_pkg;

    localparam int SPRITE_STORE_BYTES = 256;
    localparam int SPR_AW = $clog2(SPRITE_STORE_BYTES);

    // Request kinds.
    localparam logic [2:0] REQ_WRITE      = 3'd0;
    localparam logic [2:0] REQ_READ       = 3'd1;
    localparam logic [2:0] REQ_VBL_START  = 3'd2;
    localparam logic [2:0] REQ_VBL_END    = 3'd3;
    localparam logic [2:0] REQ_ZERO_HIT   = 3'd4;
    localparam logic [2:0] REQ_OVERFLOW   = 3'd5;

    // Register port numbers.
    localparam logic [2:0] PORT_CTRL      = 3'd0;
    localparam logic [2:0] PORT_MASK      = 3'd1;
    localparam logic [2:0] PORT_STATUS    = 3'd2;
    localparam logic [2:0] PORT_SPR_ADDR  = 3'd3;
    localparam logic [2:0] PORT_SPR_DATA  = 3'd4;
    localparam logic [2:0] PORT_SCROLL    = 3'd5;
    localparam logic [2:0] PORT_ADDR      = 3'd6;
    localparam logic [2:0] PORT_DATA      = 3'd7;

    // Status flag bit positions.
    localparam int FLAG_OVERFLOW = 0;
    localparam int FLAG_ZERO_HIT = 1;
    localparam int FLAG_VBLANK   = 2;

    localparam logic [13:0] PALETTE_BASE = 14'h3F00;

    typedef struct packed {
        logic              we;
        logic [SPR_AW-1:0] addr;
        logic [7:0]        data;
    } spr_wr_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] vram_address;
        logic        vram_read_strobe;
        logic        vram_write_strobe;
        logic [7:0]  vram_write_data;
        logic        nmi_request;
        logic [7:0]  control_byte;
        logic [7:0]  mask_byte;
        logic [15:0] temp_address;
        logic [2:0]  fine_x_scroll;
    } rsp_t;

endpackage

// ----- rtl/vrp_if.sv -----
interface vrp_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [2:0] reg_address;
    logic [7:0] write_data;
    logic [7:0] vram_byte;
    logic [7:0] vram_byte_below;

    modport source (
        output valid, req_type, reg_address, write_data, vram_byte, vram_byte_below,
        input  ready
    );
    modport sink (
        input  valid, req_type, reg_address, write_data, vram_byte, vram_byte_below,
        output ready
    );
endinterface

interface vrp_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [15:0] vram_address;
    logic        vram_read_strobe;
    logic        vram_write_strobe;
    logic [7:0]  vram_write_data;
    logic        nmi_request;
    logic [7:0]  control_byte;
    logic [7:0]  mask_byte;
    logic [15:0] temp_address;
    logic [2:0]  fine_x_scroll;

    modport source (
        output valid, read_data, vram_address, vram_read_strobe, vram_write_strobe,
               vram_write_data, nmi_request, control_byte, mask_byte, temp_address,
               fine_x_scroll,
        input  ready
    );
    modport sink (
        input  valid, read_data, vram_address, vram_read_strobe, vram_write_strobe,
               vram_write_data, nmi_request, control_byte, mask_byte, temp_address,
               fine_x_scroll,
        output ready
    );
endinterface

// ----- rtl/video_register_port_with_scroll_unit.sv -----
// CPU register port of a tile video processor: eight ports for control, mask, status,
// sprite address and data, scroll, video address and video data, plus event beats that
// set or clear the status flags (vblank start raises nmi_request when control bit 7 is
// set). Every request beat produces exactly one response beat. A beat is taken every
// clock: all register updates happen at the accepting edge and the response sits in an
// output register, so the port sustains one beat per cycle, stalling only while the
// response register is full and not being drained. The 256-byte sprite store reads as
// zero after reset; its read data is prefetched for the next sprite address so a data
// port read does not wait on the store.
module video_register_port_with_scroll_unit (
    input logic      clk,
    input logic      rst_n,
    vrp_req_if.sink  req,
    vrp_rsp_if.source rsp
);

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  last_wr_reg, last_wr_next;
    logic [vrp_pkg::SPR_AW-1:0] spr_addr_reg, spr_addr_next;
    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] tmp_addr_reg, tmp_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic        out_valid_reg;
    vrp_pkg::rsp_t rsp_reg, rsp_next;

    logic             accept;
    logic [15:0]      addr_step;
    logic [7:0]       spr_data;
    vrp_pkg::spr_wr_t spr_wr;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign addr_step = control_reg[2] ? 16'd32 : 16'd1;

    vrp_sprite_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (spr_wr),
        .rd_addr (spr_addr_next),
        .rd_data (spr_data)
    );

    always_comb
    begin
        control_next  = control_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        last_wr_next  = last_wr_reg;
        spr_addr_next = spr_addr_reg;
        cur_addr_next = cur_addr_reg;
        tmp_addr_next = tmp_addr_reg;
        fine_x_next   = fine_x_reg;
        toggle_next   = toggle_reg;
        rbuf_next     = rbuf_reg;

        spr_wr.we   = 1'b0;
        spr_wr.addr = spr_addr_reg;
        spr_wr.data = req.write_data;

        rsp_next = '0;
        rsp_next.vram_address = cur_addr_reg;

        if (accept)
        begin
            case (req.req_type)
                vrp_pkg::REQ_WRITE:
                begin
                    last_wr_next = req.write_data;
                    case (req.reg_address)
                        vrp_pkg::PORT_CTRL:
                        begin
                            control_next         = req.write_data;
                            tmp_addr_next[11:10] = req.write_data[1:0];
                        end
                        vrp_pkg::PORT_MASK:
                        begin
                            mask_next = req.write_data;
                        end
                        vrp_pkg::PORT_SPR_ADDR:
                        begin
                            spr_addr_next = req.write_data;
                        end
                        vrp_pkg::PORT_SPR_DATA:
                        begin
                            spr_wr.we     = 1'b1;
                            spr_addr_next = spr_addr_reg + 1'b1;
                        end
                        vrp_pkg::PORT_SCROLL:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next[4:0] = req.write_data[7:3];
                                fine_x_next        = req.write_data[2:0];
                            end
                            else
                            begin
                                tmp_addr_next[14:12] = req.write_data[2:0];
                                tmp_addr_next[9:5]   = req.write_data[7:3];
                            end
                            toggle_next = !toggle_reg;
                        end
                        vrp_pkg::PORT_ADDR:
                        begin
                            if (!toggle_reg)
                            begin
                                tmp_addr_next[14]   = 1'b0;
                                tmp_addr_next[13:8] = req.write_data[5:0];
                            end
                            else
                            begin
                                tmp_addr_next[7:0] = req.write_data;
                                cur_addr_next      = tmp_addr_next;
                            end
                            toggle_next = !toggle_reg;
                        end
                        vrp_pkg::PORT_DATA:
                        begin
                            rsp_next.vram_write_strobe = 1'b1;
                            rsp_next.vram_write_data   = req.write_data;
                            cur_addr_next              = cur_addr_reg + addr_step;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                vrp_pkg::REQ_READ:
                begin
                    case (req.reg_address)
                        vrp_pkg::PORT_STATUS:
                        begin
                            rsp_next.read_data = {status_reg, last_wr_reg[4:0]};
                            status_next[vrp_pkg::FLAG_VBLANK] = 1'b0;
                            toggle_next = 1'b0;
                        end
                        vrp_pkg::PORT_SPR_DATA:
                        begin
                            rsp_next.read_data = spr_data;
                        end
                        vrp_pkg::PORT_DATA:
                        begin
                            rsp_next.vram_read_strobe = 1'b1;
                            // Palette space bypasses the read buffer.
                            if (cur_addr_reg[13:0] < vrp_pkg::PALETTE_BASE)
                            begin
                                rsp_next.read_data = rbuf_reg;
                                rbuf_next          = req.vram_byte;
                            end
                            else
                            begin
                                rsp_next.read_data = req.vram_byte;
                                rbuf_next          = req.vram_byte_below;
                            end
                            cur_addr_next = cur_addr_reg + addr_step;
                        end
                        default:
                        begin
                            rsp_next.read_data = last_wr_reg;
                        end
                    endcase
                end
                vrp_pkg::REQ_VBL_START:
                begin
                    status_next[vrp_pkg::FLAG_VBLANK] = 1'b1;
                    rsp_next.nmi_request = control_reg[7];
                end
                vrp_pkg::REQ_VBL_END:
                begin
                    status_next = 3'd0;
                end
                vrp_pkg::REQ_ZERO_HIT:
                begin
                    status_next[vrp_pkg::FLAG_ZERO_HIT] = 1'b1;
                end
                vrp_pkg::REQ_OVERFLOW:
                begin
                    status_next[vrp_pkg::FLAG_OVERFLOW] = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        rsp_next.control_byte  = control_next;
        rsp_next.mask_byte     = mask_next;
        rsp_next.temp_address  = tmp_addr_next;
        rsp_next.fine_x_scroll = fine_x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            last_wr_reg   <= '0;
            spr_addr_reg  <= '0;
            cur_addr_reg  <= '0;
            tmp_addr_reg  <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            rbuf_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            control_reg  <= control_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            last_wr_reg  <= last_wr_next;
            spr_addr_reg <= spr_addr_next;
            cur_addr_reg <= cur_addr_next;
            tmp_addr_reg <= tmp_addr_next;
            fine_x_reg   <= fine_x_next;
            toggle_reg   <= toggle_next;
            rbuf_reg     <= rbuf_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = rsp_reg.read_data;
    assign rsp.vram_address      = rsp_reg.vram_address;
    assign rsp.vram_read_strobe  = rsp_reg.vram_read_strobe;
    assign rsp.vram_write_strobe = rsp_reg.vram_write_strobe;
    assign rsp.vram_write_data   = rsp_reg.vram_write_data;
    assign rsp.nmi_request       = rsp_reg.nmi_request;
    assign rsp.control_byte      = rsp_reg.control_byte;
    assign rsp.mask_byte         = rsp_reg.mask_byte;
    assign rsp.temp_address      = rsp_reg.temp_address;
    assign rsp.fine_x_scroll     = rsp_reg.fine_x_scroll;

endmodule

// ----- rtl/vrp_sprite_store.sv -----
module vrp_sprite_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  vrp_pkg::spr_wr_t          wr,
    input  logic [vrp_pkg::SPR_AW-1:0] rd_addr,
    output logic [7:0]                rd_data
);

    logic [7:0]                           mem [vrp_pkg::SPRITE_STORE_BYTES];
    logic [vrp_pkg::SPRITE_STORE_BYTES-1:0] valid_reg;
    logic [7:0]                           rd_data_reg;
    logic                                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Entries never written since reset read as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule

// ----- tb/video_register_port_with_scroll_unit_tb.sv -----
`timescale 1ns / 1ps

module video_register_port_with_scroll_unit_tb;

    // Event codes that the block takes but ignores.
    localparam logic [2:0] REQ_IGNORED_A = 3'd6;
    localparam logic [2:0] REQ_IGNORED_B = 3'd7;

    localparam int CTRL_NMI_ENABLE   = 7;
    localparam int CTRL_VADDR_STEP32 = 2;

    localparam int RANDOM_BEATS = 750;
    localparam int WRAP_RUN     = 48;

    typedef struct {
        logic [2:0] kind;
        logic [2:0] port;
        logic [7:0] data;
        logic [7:0] mem;
        logic [7:0] mem_below;
        bit         calm;
        bit         hold_for_drain;
    } cpu_beat_t;

    logic clk;
    logic rst_n;

    vrp_req_if req_bus ();
    vrp_rsp_if rsp_bus ();

    video_register_port_with_scroll_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    cpu_beat_t     bus_beats_pending[$];
    vrp_pkg::rsp_t predicted_rsps[$];

    // Shadow copy of the register port.
    logic [7:0]  shadow_ctrl;
    logic [7:0]  shadow_mask;
    logic [2:0]  shadow_flags;
    logic [7:0]  shadow_last;
    logic [7:0]  shadow_spr [vrp_pkg::SPRITE_STORE_BYTES];
    logic [7:0]  shadow_spr_ptr;
    logic [15:0] shadow_vaddr;
    logic [15:0] shadow_tmp;
    logic [2:0]  shadow_fine_x;
    logic        shadow_toggle;
    logic [7:0]  shadow_rd_buf;

    int        mismatches;
    int        beats_queued;
    bit        fill_calm;
    bit        fill_drain;

    bit        req_taken;
    bit        rsp_taken;
    bit        beat_loaded;
    bit        presenting;
    bit        pace_calm;
    int        gap_left;
    int        stall_left;
    cpu_beat_t cur_beat;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic vrp_pkg::rsp_t predict_access(cpu_beat_t b);
        vrp_pkg::rsp_t r;
        logic [15:0] step;
        r = '0;
        r.vram_address = shadow_vaddr;
        step = shadow_ctrl[CTRL_VADDR_STEP32] ? 16'd32 : 16'd1;
        case (b.kind)
            vrp_pkg::REQ_WRITE:
            begin
                shadow_last = b.data;
                case (b.port)
                    vrp_pkg::PORT_CTRL:
                    begin
                        shadow_ctrl = b.data;
                        shadow_tmp[11:10] = b.data[1:0];
                    end
                    vrp_pkg::PORT_MASK: shadow_mask = b.data;
                    vrp_pkg::PORT_SPR_ADDR: shadow_spr_ptr = b.data;
                    vrp_pkg::PORT_SPR_DATA:
                    begin
                        shadow_spr[shadow_spr_ptr] = b.data;
                        shadow_spr_ptr = shadow_spr_ptr + 8'd1;
                    end
                    vrp_pkg::PORT_SCROLL:
                    begin
                        if (!shadow_toggle)
                        begin
                            shadow_tmp[4:0] = b.data[7:3];
                            shadow_fine_x = b.data[2:0];
                        end
                        else
                        begin
                            shadow_tmp[14:12] = b.data[2:0];
                            shadow_tmp[9:5] = b.data[7:3];
                        end
                        shadow_toggle = !shadow_toggle;
                    end
                    vrp_pkg::PORT_ADDR:
                    begin
                        if (!shadow_toggle)
                        begin
                            shadow_tmp[14:8] = {1'b0, b.data[5:0]};
                        end
                        else
                        begin
                            shadow_tmp[7:0] = b.data;
                            shadow_vaddr = shadow_tmp;
                        end
                        shadow_toggle = !shadow_toggle;
                    end
                    vrp_pkg::PORT_DATA:
                    begin
                        r.vram_write_strobe = 1'b1;
                        r.vram_write_data = b.data;
                        shadow_vaddr = shadow_vaddr + step;
                    end
                    default: ;
                endcase
            end
            vrp_pkg::REQ_READ:
            begin
                case (b.port)
                    vrp_pkg::PORT_STATUS:
                    begin
                        r.read_data = {shadow_flags, shadow_last[4:0]};
                        shadow_flags[vrp_pkg::FLAG_VBLANK] = 1'b0;
                        shadow_toggle = 1'b0;
                    end
                    vrp_pkg::PORT_SPR_DATA: r.read_data = shadow_spr[shadow_spr_ptr];
                    vrp_pkg::PORT_DATA:
                    begin
                        r.vram_read_strobe = 1'b1;
                        // Palette entries come straight back; the buffer then holds
                        // the name table byte that sits underneath them.
                        if (shadow_vaddr[13:0] < vrp_pkg::PALETTE_BASE)
                        begin
                            r.read_data = shadow_rd_buf;
                            shadow_rd_buf = b.mem;
                        end
                        else
                        begin
                            r.read_data = b.mem;
                            shadow_rd_buf = b.mem_below;
                        end
                        shadow_vaddr = shadow_vaddr + step;
                    end
                    default: r.read_data = shadow_last;
                endcase
            end
            vrp_pkg::REQ_VBL_START:
            begin
                shadow_flags[vrp_pkg::FLAG_VBLANK] = 1'b1;
                r.nmi_request = shadow_ctrl[CTRL_NMI_ENABLE];
            end
            vrp_pkg::REQ_VBL_END: shadow_flags = '0;
            vrp_pkg::REQ_ZERO_HIT: shadow_flags[vrp_pkg::FLAG_ZERO_HIT] = 1'b1;
            vrp_pkg::REQ_OVERFLOW: shadow_flags[vrp_pkg::FLAG_OVERFLOW] = 1'b1;
            default: ;
        endcase
        r.control_byte = shadow_ctrl;
        r.mask_byte = shadow_mask;
        r.temp_address = shadow_tmp;
        r.fine_x_scroll = shadow_fine_x;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_beat(input logic [2:0] kind, input logic [2:0] port,
                              input logic [7:0] data);
        cpu_beat_t b;
        b.kind = kind;
        b.port = port;
        b.data = data;
        b.mem = 8'($urandom_range(0, 255));
        b.mem_below = 8'($urandom_range(0, 255));
        b.calm = fill_calm;
        b.hold_for_drain = fill_drain;
        fill_drain = 1'b0;
        bus_beats_pending.push_back(b);
        beats_queued++;
    endtask

    // Response side is checked before the new request is predicted, so a stray
    // response in the same cycle as a request is never hidden.
    always @(posedge clk)
    begin
        vrp_pkg::rsp_t want;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                rsp_taken = 1'b1;
                if (predicted_rsps.size() == 0)
                begin
                    $error("response beat with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = predicted_rsps.pop_front();
                    check_field("read_data", 16'(want.read_data),
                                16'(rsp_bus.read_data));
                    check_field("vram_address", want.vram_address, rsp_bus.vram_address);
                    check_field("vram_read_strobe", 16'(want.vram_read_strobe),
                                16'(rsp_bus.vram_read_strobe));
                    check_field("vram_write_strobe", 16'(want.vram_write_strobe),
                                16'(rsp_bus.vram_write_strobe));
                    check_field("vram_write_data", 16'(want.vram_write_data),
                                16'(rsp_bus.vram_write_data));
                    check_field("nmi_request", 16'(want.nmi_request),
                                16'(rsp_bus.nmi_request));
                    check_field("control_byte", 16'(want.control_byte),
                                16'(rsp_bus.control_byte));
                    check_field("mask_byte", 16'(want.mask_byte),
                                16'(rsp_bus.mask_byte));
                    check_field("temp_address", want.temp_address, rsp_bus.temp_address);
                    check_field("fine_x_scroll", 16'(want.fine_x_scroll),
                                16'(rsp_bus.fine_x_scroll));
                end
            end
            if (req_bus.valid && req_bus.ready)
            begin
                predicted_rsps.push_back(predict_access(cur_beat));
                req_taken = 1'b1;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                req_taken = 1'b0;
                beat_loaded = 1'b0;
                presenting = 1'b0;
            end
            if (!beat_loaded && bus_beats_pending.size() > 0)
            begin
                cur_beat = bus_beats_pending.pop_front();
                beat_loaded = 1'b1;
                pace_calm = cur_beat.calm;
                gap_left = cur_beat.calm ? 0 : $urandom_range(0, 16);
            end
            if (beat_loaded && !presenting)
            begin
                if (!(cur_beat.hold_for_drain && predicted_rsps.size() != 0))
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else
                        presenting = 1'b1;
                end
            end
            req_bus.valid <= presenting;
            if (presenting)
            begin
                req_bus.req_type <= cur_beat.kind;
                req_bus.reg_address <= cur_beat.port;
                req_bus.write_data <= cur_beat.data;
                req_bus.vram_byte <= cur_beat.mem;
                req_bus.vram_byte_below <= cur_beat.mem_below;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_taken)
            begin
                rsp_taken = 1'b0;
                stall_left = pace_calm ? 0 : $urandom_range(0, 16);
            end
            if (stall_left != 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int choice;
        int n;
        int k;
        int next_switch;
        bit wrap_done;
        logic [7:0] spr_base;

        req_bus.valid = 1'b0;
        req_bus.req_type = vrp_pkg::REQ_WRITE;
        req_bus.reg_address = vrp_pkg::PORT_CTRL;
        req_bus.write_data = '0;
        req_bus.vram_byte = '0;
        req_bus.vram_byte_below = '0;
        rsp_bus.ready = 1'b0;
        rst_n = 1'b0;

        shadow_ctrl = '0;
        shadow_mask = '0;
        shadow_flags = '0;
        shadow_last = '0;
        shadow_spr_ptr = '0;
        shadow_vaddr = '0;
        shadow_tmp = '0;
        shadow_fine_x = '0;
        shadow_toggle = 1'b0;
        shadow_rd_buf = '0;
        for (k = 0; k < vrp_pkg::SPRITE_STORE_BYTES; k++)
            shadow_spr[k] = '0;
        mismatches = 0;
        beats_queued = 0;
        fill_calm = 1'b0;
        fill_drain = 1'b0;
        req_taken = 1'b0;
        rsp_taken = 1'b0;
        beat_loaded = 1'b0;
        presenting = 1'b0;
        pace_calm = 1'b0;
        gap_left = 0;
        stall_left = 0;
        wrap_done = 1'b0;

        // Directed part: reads at reset, every event, the status port write,
        // sprite address wrap, both scroll writes and palette versus buffered reads.
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_MASK, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_SPR_ADDR, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_SCROLL, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_ADDR, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_CTRL, 8'h87);
        queue_beat(vrp_pkg::REQ_VBL_START, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(vrp_pkg::REQ_ZERO_HIT, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(vrp_pkg::REQ_OVERFLOW, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
        queue_beat(vrp_pkg::REQ_VBL_END, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(REQ_IGNORED_A, vrp_pkg::PORT_DATA, 8'hFF);
        queue_beat(REQ_IGNORED_B, vrp_pkg::PORT_DATA, 8'hFF);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_MASK, 8'hFF);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_STATUS, 8'hA5);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_CTRL, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_ADDR, 8'hFF);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_DATA, 8'h5A);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_SPR_DATA, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_ADDR, 8'hFF);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_SPR_DATA, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SCROLL, 8'hFF);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SCROLL, 8'hFF);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'h3F);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'h00);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_DATA, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'hFE);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'hFF);
        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_DATA, 8'h00);
        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_DATA, 8'h00);

        // The random part opens only once the directed beats have all come back.
        fill_drain = 1'b1;
        beats_queued = 0;
        next_switch = 0;
        while (beats_queued < RANDOM_BEATS)
        begin
            if (beats_queued >= next_switch)
            begin
                fill_calm = ($urandom_range(0, 3) == 0);
                next_switch = beats_queued + $urandom_range(20, 80);
            end
            if (!wrap_done && beats_queued > RANDOM_BEATS / 2)
            begin
                // Step the video address by 32 from just below the top of the
                // 14-bit space on into the addresses above it.
                wrap_done = 1'b1;
                fill_calm = 1'b1;
                queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
                queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_CTRL,
                           8'($urandom_range(0, 255)) | (8'd1 << CTRL_VADDR_STEP32));
                queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'hFF);
                queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR, 8'hE0);
                for (k = 0; k < WRAP_RUN; k++)
                    queue_beat($urandom_range(0, 1) ? vrp_pkg::REQ_READ : vrp_pkg::REQ_WRITE,
                               vrp_pkg::PORT_DATA, 8'($urandom_range(0, 255)));
                fill_calm = 1'b0;
            end
            choice = $urandom_range(0, 9);
            case (choice)
                0:
                begin
                    if ($urandom_range(0, 2) != 0)
                        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SCROLL,
                               8'($urandom_range(0, 255)));
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SCROLL,
                               8'($urandom_range(0, 255)));
                end
                1, 2:
                begin
                    queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
                    if ($urandom_range(0, 3) == 0)
                        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR,
                                   {2'($urandom_range(0, 3)), 6'h3F});
                    else
                        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR,
                                   8'($urandom_range(0, 255)));
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_ADDR,
                               8'($urandom_range(0, 255)));
                    n = $urandom_range(1, 6);
                    for (k = 0; k < n; k++)
                        queue_beat($urandom_range(0, 2) != 0 ? vrp_pkg::REQ_READ
                                                             : vrp_pkg::REQ_WRITE,
                                   vrp_pkg::PORT_DATA, 8'($urandom_range(0, 255)));
                end
                3:
                begin
                    spr_base = 8'($urandom_range(0, 255));
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_ADDR, spr_base);
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_DATA,
                                   8'($urandom_range(0, 255)));
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_ADDR, spr_base);
                    for (k = 0; k < n; k++)
                    begin
                        queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_SPR_DATA, 8'h00);
                        if ($urandom_range(0, 1))
                            queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_SPR_DATA,
                                       8'($urandom_range(0, 255)));
                    end
                end
                4:
                begin
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_CTRL,
                               8'($urandom_range(0, 255)));
                    queue_beat(vrp_pkg::REQ_WRITE, vrp_pkg::PORT_MASK,
                               8'($urandom_range(0, 255)));
                end
                5:
                begin
                    n = $urandom_range(1, 4);
                    for (k = 0; k < n; k++)
                        queue_beat(3'($urandom_range(vrp_pkg::REQ_VBL_START, REQ_IGNORED_B)),
                                   3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    queue_beat(vrp_pkg::REQ_READ, vrp_pkg::PORT_STATUS, 8'h00);
                end
                6:
                begin
                    queue_beat(vrp_pkg::REQ_READ, 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)));
                end
                7:
                begin
                    queue_beat(vrp_pkg::REQ_WRITE, 3'($urandom_range(0, 7)),
                               8'($urandom_range(0, 255)));
                end
                default:
                begin
                    n = $urandom_range(1, 3);
                    for (k = 0; k < n; k++)
                        queue_beat(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                   8'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bus_beats_pending.size() != 0 || beat_loaded)
            @(posedge clk);
        while (predicted_rsps.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
